>>> design/channel_bar_graph_scaler_top_assert.svh
// assertion macros for the channel bar graph scaler checker
// expects signals clk and rst_n in the scope of each use
`ifndef CHANNEL_BAR_GRAPH_SCALER_TOP_ASSERT_SVH
`define CHANNEL_BAR_GRAPH_SCALER_TOP_ASSERT_SVH

// property checked outside reset
`define CBGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CBGS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/cbgs_pkg.sv
// shared types and constants for the channel bar graph scaler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbgs_pkg;

    localparam int SAMPLE_W = 12;
    localparam int RANGE_W  = 13;
    localparam int CHAN_W   = 6;
    localparam int COL_W    = 7;
    localparam int HGT_W    = 6;
    localparam int NUM_W    = SAMPLE_W + HGT_W;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_DRAW  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic KIND_BAR    = 1'b0;
    localparam logic KIND_CURSOR = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_RESET  = 12'd1;
    localparam logic [RANGE_W-1:0]  MIN_RESET     = 13'd4095;
    localparam logic [RANGE_W-1:0]  MAX_RESET     = 13'd0;
    localparam int                  CURSOR_RESET  = 20;
    localparam logic [HGT_W-1:0]    CURSOR_HEIGHT = 6'd2;

    // middle column of a bar, wrapped to the display width
    function automatic logic [COL_W-1:0] column_of(input logic [CHAN_W-1:0] idx);
        logic [8:0] col;
        col = 9'd5 + 9'd3 * {3'b000, idx};
        return col[COL_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/channel_bar_graph_scaler_top.sv
// channel bar graph scaler: sample memory, running range and draw sequencer
// depends on cbgs_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// cmd      in         cmd_valid/cmd_ready  op, channel_index, sample_value
// bar      out        bar_valid/bar_ready  item_kind, column_x, top_row, bar_height, last
//
// store and step items complete without leaving idle; cmd_ready is high only in idle
// a draw takes per channel one memory read, one scaling step, six divider
// steps and one output load, and ends with the cursor item
// (channels that scale trivially skip the divider steps)
// a stalled bar channel holds the sequencer at its output load; the cursor item
// sits in the output register while the next cmd item is already taken
// async reset, no clearing pass: per-channel fill bits make unwritten samples read as 1

module channel_bar_graph_scaler_top #(
    parameter int NUM_CHANNELS    = 40,
    parameter int BAR_AREA_HEIGHT = 54
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // command channel
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire logic [1:0]                       op,
    input  wire logic [cbgs_pkg::CHAN_W-1:0]      channel_index,
    input  wire logic [cbgs_pkg::SAMPLE_W-1:0]    sample_value,
    // bar channel
    output logic                                  bar_valid,
    input  wire logic                             bar_ready,
    output logic                                  item_kind,
    output logic [cbgs_pkg::COL_W-1:0]            column_x,
    output logic [cbgs_pkg::HGT_W-1:0]            top_row,
    output logic [cbgs_pkg::HGT_W-1:0]            bar_height,
    output logic                                  last
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
    localparam logic [cbgs_pkg::HGT_W-1:0] BAR_H = cbgs_pkg::HGT_W'(BAR_AREA_HEIGHT);
    localparam logic [cbgs_pkg::CHAN_W-1:0] NUM_CH = cbgs_pkg::CHAN_W'(NUM_CHANNELS);
    localparam logic [cbgs_pkg::CHAN_W-1:0] CUR_RST = cbgs_pkg::CHAN_W'(cbgs_pkg::CURSOR_RESET);
    // the only cursor value at or above the channel count is the reset value
    localparam logic [cbgs_pkg::CHAN_W-1:0] CUR_WRAP =
        cbgs_pkg::CHAN_W'((cbgs_pkg::CURSOR_RESET + 1) % NUM_CHANNELS);
    localparam logic [2:0] DIV_LAST = 3'(cbgs_pkg::HGT_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCALE,
        S_DIV,
        S_EMIT,
        S_CURSOR
    } state_t;

    // sample memory, one synchronous read port and one write port
    logic [cbgs_pkg::SAMPLE_W-1:0] sample_mem [NUM_CHANNELS];
    logic [cbgs_pkg::SAMPLE_W-1:0] rd_data_reg;

    state_t                          state_reg;
    logic [NUM_CHANNELS-1:0]         filled_reg;
    logic [cbgs_pkg::RANGE_W-1:0]    min_reg;
    logic [cbgs_pkg::RANGE_W-1:0]    max_reg;
    logic [cbgs_pkg::CHAN_W-1:0]     cursor_reg;
    logic                            seen_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [cbgs_pkg::RANGE_W-1:0]    den_reg;
    logic [cbgs_pkg::RANGE_W-1:0]    rem_reg;
    logic [cbgs_pkg::HGT_W-1:0]      quo_reg;
    logic [2:0]                      cnt_reg;
    logic                            bar_valid_reg;
    logic                            kind_reg;
    logic [cbgs_pkg::COL_W-1:0]      col_reg;
    logic [cbgs_pkg::HGT_W-1:0]      top_reg;
    logic [cbgs_pkg::HGT_W-1:0]      hgt_reg;
    logic                            last_reg;

    logic                            cmd_take;
    cbgs_pkg::op_t                   cmd_op;
    logic                            ch_ok;
    logic                            store_we;
    logic [IDX_W-1:0]                wr_idx;
    logic [cbgs_pkg::RANGE_W-1:0]    sample_ext;
    logic [cbgs_pkg::RANGE_W-1:0]    min_next;
    logic [cbgs_pkg::RANGE_W-1:0]    max_pick;
    logic [cbgs_pkg::RANGE_W-1:0]    max_next;
    logic [cbgs_pkg::CHAN_W-1:0]     cursor_next;
    logic [cbgs_pkg::SAMPLE_W-1:0]   cur_sample;
    logic                            trivial;
    logic [cbgs_pkg::SAMPLE_W-1:0]   diff;
    logic [cbgs_pkg::NUM_W-1:0]      product;
    logic [cbgs_pkg::RANGE_W:0]      shifted;
    logic                            fits;
    logic [cbgs_pkg::HGT_W-1:0]      height;
    logic                            out_free;
    logic                            bar_load;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign cmd_take   = cmd_valid && cmd_ready;
    assign cmd_op     = cbgs_pkg::op_t'(op);
    assign ch_ok      = (channel_index < NUM_CH);
    assign store_we   = cmd_take && (cmd_op == cbgs_pkg::OP_STORE) && ch_ok;
    assign wr_idx     = channel_index[IDX_W-1:0];

    // running range update for a store
    assign sample_ext = {1'b0, sample_value};
    assign min_next   = (sample_ext < min_reg) ? sample_ext : min_reg;
    assign max_pick   = (sample_ext > max_reg) ? sample_ext : max_reg;
    assign max_next   = (min_next == max_pick) ? max_pick + 1'b1 : max_pick;

    // cursor advance, wrapping at the channel count
    always_comb
    begin
        if (cursor_reg >= NUM_CH)
        begin
            cursor_next = CUR_WRAP;
        end
        else if (cursor_reg == NUM_CH - 1'b1)
        begin
            cursor_next = '0;
        end
        else
        begin
            cursor_next = cursor_reg + 1'b1;
        end
    end

    // scaling: the product is below 64 * span, so only six quotient bits remain
    assign cur_sample = filled_reg[idx_reg] ? rd_data_reg : cbgs_pkg::SAMPLE_RESET;
    assign trivial    = !seen_reg || ({1'b0, cur_sample} <= min_reg) || (max_reg <= min_reg);
    assign diff       = cur_sample - min_reg[cbgs_pkg::SAMPLE_W-1:0];
    assign product    = cbgs_pkg::NUM_W'(BAR_H) * cbgs_pkg::NUM_W'(diff);

    // one restoring divider step a cycle
    assign shifted    = {rem_reg, quo_reg[cbgs_pkg::HGT_W-1]};
    assign fits       = (shifted >= {1'b0, den_reg});

    // clamp to one pixel minimum and the bar area maximum
    always_comb
    begin
        if (quo_reg == '0)
        begin
            height = 6'd1;
        end
        else if (quo_reg > BAR_H)
        begin
            height = BAR_H;
        end
        else
        begin
            height = quo_reg;
        end
    end

    assign out_free = !bar_valid_reg || bar_ready;

    // an item is loaded whenever the output register is free in an emitting state
    assign bar_load = ((state_reg == S_EMIT) || (state_reg == S_CURSOR)) && out_free;

    // stores only happen in idle, so the read that a draw uses never meets a write
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            sample_mem[wr_idx] <= sample_value;
        end
        rd_data_reg <= sample_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filled_reg    <= '0;
            min_reg       <= cbgs_pkg::MIN_RESET;
            max_reg       <= cbgs_pkg::MAX_RESET;
            cursor_reg    <= CUR_RST;
            seen_reg      <= 1'b0;
            idx_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            bar_valid_reg <= 1'b0;
            kind_reg      <= cbgs_pkg::KIND_BAR;
            col_reg       <= '0;
            top_reg       <= '0;
            hgt_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (bar_load)
            begin
                bar_valid_reg <= 1'b1;
            end
            else if (bar_ready)
            begin
                bar_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        case (cmd_op)
                            cbgs_pkg::OP_STORE:
                            begin
                                if (ch_ok)
                                begin
                                    filled_reg[wr_idx] <= 1'b1;
                                    min_reg            <= min_next;
                                    max_reg            <= max_next;
                                    seen_reg           <= 1'b1;
                                end
                            end
                            cbgs_pkg::OP_DRAW:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_READ;
                            end
                            cbgs_pkg::OP_STEP:
                            begin
                                cursor_reg <= cursor_next;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // memory output lands in rd_data_reg at this edge
                S_READ:
                begin
                    state_reg <= S_SCALE;
                end

                S_SCALE:
                begin
                    den_reg <= max_reg - min_reg;
                    cnt_reg <= '0;
                    if (trivial)
                    begin
                        quo_reg   <= 6'd1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        rem_reg   <= {1'b0, product[cbgs_pkg::NUM_W-1:cbgs_pkg::HGT_W]};
                        quo_reg   <= product[cbgs_pkg::HGT_W-1:0];
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg <= fits ? cbgs_pkg::RANGE_W'(shifted - {1'b0, den_reg})
                                    : shifted[cbgs_pkg::RANGE_W-1:0];
                    quo_reg <= {quo_reg[cbgs_pkg::HGT_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= cbgs_pkg::KIND_BAR;
                        col_reg       <= cbgs_pkg::column_of(cbgs_pkg::CHAN_W'(idx_reg));
                        top_reg       <= BAR_H - height;
                        hgt_reg       <= height;
                        last_reg      <= 1'b0;
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_CURSOR;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end

                S_CURSOR:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= cbgs_pkg::KIND_CURSOR;
                        col_reg       <= cbgs_pkg::column_of(cursor_reg);
                        top_reg       <= BAR_H;
                        hgt_reg       <= cbgs_pkg::CURSOR_HEIGHT;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign bar_valid  = bar_valid_reg;
    assign item_kind  = kind_reg;
    assign column_x   = col_reg;
    assign top_row    = top_reg;
    assign bar_height = hgt_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

>>> design/cbgs_checker.sv
// port-level checks for the channel bar graph scaler, bound to the top level
// depends on cbgs_pkg and channel_bar_graph_scaler_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "channel_bar_graph_scaler_top_assert.svh"

module cbgs_checker #(
    parameter int BAR_AREA_HEIGHT = 54
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic [1:0]                    op,
    input wire logic                          bar_valid,
    input wire logic                          bar_ready,
    input wire logic                          item_kind,
    input wire logic [cbgs_pkg::HGT_W-1:0]    top_row,
    input wire logic [cbgs_pkg::HGT_W-1:0]    bar_height,
    input wire logic                          last
);

    localparam logic [cbgs_pkg::HGT_W-1:0] BAR_H = cbgs_pkg::HGT_W'(BAR_AREA_HEIGHT);

    // a stalled item stays offered
    `CBGS_ASSERT(a_bar_hold, bar_valid && !bar_ready |=> bar_valid, "bar item dropped while stalled")

    // nothing is offered while reset is held
    `CBGS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !bar_valid, "bar item offered during reset")

    // only the cursor item closes a draw run
    `CBGS_ASSERT(a_last_cursor, bar_valid |-> (last == item_kind), "last flag and item kind disagree")

    // a bar fills the area from its top row down, at least one pixel
    `CBGS_ASSERT(a_bar_geometry, bar_valid && (item_kind == cbgs_pkg::KIND_BAR) |-> (bar_height != '0) && (top_row + bar_height == BAR_H), "bar height and top row inconsistent")

    // a draw run blocks further commands on the next cycle
    `CBGS_ASSERT(a_draw_busy, cmd_valid && cmd_ready && (op == cbgs_pkg::OP_DRAW) |=> !cmd_ready, "command taken during a draw run")

endmodule

bind channel_bar_graph_scaler_top cbgs_checker #(
    .BAR_AREA_HEIGHT(BAR_AREA_HEIGHT)
) u_cbgs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .op         (op),
    .bar_valid  (bar_valid),
    .bar_ready  (bar_ready),
    .item_kind  (item_kind),
    .top_row    (top_row),
    .bar_height (bar_height),
    .last       (last)
);

`default_nettype wire
